/* hdl/bresenham_line_rasterizer_assert.svh */
// Assertion macros for the line rasterizer checker.
// Clocked on clk, with reset rst_n (active low); no other dependencies.
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

// Checked only while out of reset.
`define BLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, also while reset is held.
`define BLR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/blr_pkg.sv */
// Shared constants, types and helpers for the line rasterizer.
// Used by blr_ctrl, blr_datapath, the top level and blr_checker; no dependencies.
`default_nettype none

package blr_pkg;

  // Coordinate bits actually used from each 6-bit endpoint field.
  localparam int COORD_BITS  = 6;
  localparam int IN_COORD_W  = 6;
  localparam int PIX_W       = 12;
  localparam int OFFSET_W    = 10;
  localparam int COLOUR_W    = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int ERR_W       = COORD_BITS + 3;
  localparam int IN_TDATA_W  = 4 * IN_COORD_W;
  localparam int OUT_TDATA_W = 2 * PIX_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [COLOUR_W-1:0] {
    COLOUR_STEEP  = 2'd0,
    COLOUR_RAISED = 2'd1,
    COLOUR_FLAT   = 2'd2
  } colour_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_X = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_Y = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;   // latch a new segment
    logic step;   // emit current pixel, advance one pixel
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_valid;  // output register holds a pixel
    logic at_end;     // current pixel is the last of the line
  } dp_sts_t;

  function automatic coord_t sext_coord(logic [IN_COORD_W-1:0] v);
    return coord_t'(v[COORD_BITS-1:0]);
  endfunction

endpackage

`default_nettype wire

/* hdl/blr_ctrl.sv */
// Sequencer for the line rasterizer: idle / run state machine.
// Depends on blr_pkg; drives the datapath commands.
`default_nettype none

module blr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic            out_tready,
  input  wire blr_pkg::dp_sts_t sts,
  output blr_pkg::dp_cmd_t     cmd
);
  import blr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        // nothing is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // advance whenever the output slot is free or being drained
        cmd.step = !sts.out_valid || out_tready;
        if (cmd.step && sts.at_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/blr_datapath.sv */
// Datapath for the line rasterizer: segment setup, stepping registers,
// offset registers and the output register. Depends on blr_pkg.
`default_nettype none

module blr_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire blr_pkg::dp_cmd_t                   cmd,
  output blr_pkg::dp_sts_t                        sts,
  input  wire logic [blr_pkg::IN_COORD_W-1:0]     start_x,
  input  wire logic [blr_pkg::IN_COORD_W-1:0]     start_y,
  input  wire logic [blr_pkg::IN_COORD_W-1:0]     end_x,
  input  wire logic [blr_pkg::IN_COORD_W-1:0]     end_y,
  input  wire logic                               raised,
  input  wire logic                               cfg_we,
  input  wire logic [blr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [blr_pkg::OFFSET_W-1:0]       cfg_data,
  input  wire logic                               out_tready,
  output logic                                    out_valid,
  output logic [blr_pkg::PIX_W-1:0]               pixel_x,
  output logic [blr_pkg::PIX_W-1:0]               pixel_y,
  output blr_pkg::colour_t                        colour,
  output logic                                    last
);
  import blr_pkg::*;

  // ---- configuration ----
  logic [OFFSET_W-1:0] offset_x_r, offset_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_X: offset_x_r <= cfg_data;
        CFG_OFFSET_Y: offset_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- segment setup ----
  coord_t                   ax, ay, bx, by;
  logic signed [DIFF_W-1:0] dx, dy, mn_full;
  logic [DIFF_W-1:0]        adx, ady, md_full, amn;
  logic                     steep, swap;
  coord_t                   s0, s1, e0, e1, a0, a1, b0, b1;
  colour_t                  colour_sel;

  always_comb begin
    ax  = sext_coord(start_x);
    ay  = sext_coord(start_y);
    bx  = sext_coord(end_x);
    by  = sext_coord(end_y);
    dx  = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
    dy  = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
    adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    steep = adx < ady;
    s0 = steep ? ay : ax;
    s1 = steep ? ax : ay;
    e0 = steep ? by : bx;
    e1 = steep ? bx : by;
    swap = s0 > e0;
    a0 = swap ? e0 : s0;
    a1 = swap ? e1 : s1;
    b0 = swap ? s0 : e0;
    b1 = swap ? s1 : e1;
    md_full = {b0[COORD_BITS-1], b0} - {a0[COORD_BITS-1], a0};
    mn_full = {b1[COORD_BITS-1], b1} - {a1[COORD_BITS-1], a1};
    amn     = mn_full[DIFF_W-1] ? DIFF_W'(-mn_full) : DIFF_W'(mn_full);
    if (steep) begin
      colour_sel = COLOUR_STEEP;
    end else if (raised) begin
      colour_sel = COLOUR_RAISED;
    end else begin
      colour_sel = COLOUR_FLAT;
    end
  end

  // ---- stepping registers ----
  coord_t                    major_r, minor_r, end_r;
  logic signed [ERR_W-1:0]   err_r;
  logic [COORD_BITS-1:0]     mdelta_r;   // major delta, never negative
  logic [COORD_BITS:0]       step2_r;    // 2*|minor delta|
  logic                      neg_r, steep_r;
  colour_t                   colour_r;

  logic signed [ERR_W-1:0]   err_add, err_nxt, mdelta_s, mdelta2_s;
  logic                      bump;
  logic [COORD_BITS-1:0]     minor_inc;
  coord_t                    px, py;

  always_comb begin
    err_add   = err_r + $signed({2'b00, step2_r});
    mdelta_s  = $signed({3'b000, mdelta_r});
    mdelta2_s = $signed({2'b00, mdelta_r, 1'b0});
    bump      = err_add > mdelta_s;
    err_nxt   = bump ? err_add - mdelta2_s : err_add;
    minor_inc = neg_r ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
    px        = steep_r ? minor_r : major_r;
    py        = steep_r ? major_r : minor_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      major_r  <= a0;
      minor_r  <= a1;
      end_r    <= b0;
      err_r    <= '0;
      mdelta_r <= md_full[COORD_BITS-1:0];
      step2_r  <= {amn[COORD_BITS-1:0], 1'b0};
      neg_r    <= mn_full[DIFF_W-1];
      steep_r  <= steep;
      colour_r <= colour_sel;
    end else if (cmd.step) begin
      major_r <= major_r + coord_t'(1);
      err_r   <= err_nxt;
      if (bump) begin
        minor_r <= coord_t'(minor_r + minor_inc);
      end
    end
  end

  // ---- output register ----
  logic                 out_valid_r, last_r;
  logic [PIX_W-1:0]     pix_x_r, pix_y_r;
  colour_t              colour_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pix_x_r <= {{(PIX_W-COORD_BITS){px[COORD_BITS-1]}}, px}
               + {{(PIX_W-OFFSET_W){1'b0}}, offset_x_r};
      pix_y_r <= {{(PIX_W-COORD_BITS){py[COORD_BITS-1]}}, py}
               + {{(PIX_W-OFFSET_W){1'b0}}, offset_y_r};
      colour_out_r <= colour_r;
      last_r       <= major_r == end_r;
    end
  end

  assign sts.out_valid = out_valid_r;
  assign sts.at_end    = major_r == end_r;
  assign out_valid     = out_valid_r;
  assign pixel_x       = pix_x_r;
  assign pixel_y       = pix_y_r;
  assign colour        = colour_out_r;
  assign last          = last_r;

endmodule

`default_nettype wire

/* hdl/bresenham_line_rasterizer.sv */
// Top level of the Bresenham line rasterizer.
// Depends on blr_pkg, blr_ctrl and blr_datapath.
//
// Takes one line segment per request (two signed endpoints plus a raised
// flag) and emits the line's pixels in order along the major axis, one
// pixel request each, with the configured x/y offsets added and tlast set
// on the final pixel. Endpoints use the low COORD_BITS bits of each field,
// sign-extended. A line of N pixels (N = major delta + 1, at most 64) is
// handled in a setup step that latches the sorted endpoints and deltas,
// then by the stepping loop, which emits its pixels in order and advances
// only when the output register is free or being drained. A new segment
// is taken once the last pixel has moved into the output register, even
// while that pixel still waits downstream. The offset registers are
// written through the cfg port (ready whenever out of reset) and must be
// changed only while no line is in flight.
`default_nettype none

module bresenham_line_rasterizer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: start_x [5:0], start_y [11:6], end_x [17:12], end_y [23:18]
  input  wire logic [blr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: raised [0]
  input  wire logic                              in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // out_tdata: pixel_x [11:0], pixel_y [23:12]
  output logic [blr_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // out_tuser: colour [1:0]
  output logic [blr_pkg::COLOUR_W-1:0]           out_tuser,
  output logic                                   out_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // cfg_index 0: offset_x, 1: offset_y
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [blr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [blr_pkg::OFFSET_W-1:0]      cfg_data
);
  import blr_pkg::*;

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [PIX_W-1:0] pixel_x, pixel_y;
  colour_t          colour;

  // Offsets are plain registers, so writes never stall outside reset.
  assign cfg_ready = rst_n;

  blr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  blr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .start_x    (in_tdata[IN_COORD_W-1:0]),
    .start_y    (in_tdata[2*IN_COORD_W-1:IN_COORD_W]),
    .end_x      (in_tdata[3*IN_COORD_W-1:2*IN_COORD_W]),
    .end_y      (in_tdata[4*IN_COORD_W-1:3*IN_COORD_W]),
    .raised     (in_tuser),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .colour     (colour),
    .last       (out_tlast)
  );

  assign out_tdata = {pixel_y, pixel_x};
  assign out_tuser = colour;

endmodule

`default_nettype wire

/* hdl/blr_checker.sv */
// Port-level checker for the line rasterizer, bound to the top level.
// Depends on blr_pkg and bresenham_line_rasterizer_assert.svh.
`default_nettype none
`include "bresenham_line_rasterizer_assert.svh"

module blr_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tready,
  input  wire logic [blr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  wire logic [blr_pkg::COLOUR_W-1:0]      out_tuser,
  input  wire logic                              out_tlast,
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready
);
  import blr_pkg::*;

  // stalled pixel holds
  `BLR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "pixel changed while stalled")

  // a pending non-final pixel means the line is still running
  `BLR_ASSERT(a_no_accept_mid_line, out_tvalid && !out_tlast |-> !in_tready, "segment accepted mid-line")

  // one colour for every pixel of a line
  `BLR_ASSERT(a_colour_per_line, out_tvalid && out_tready && !out_tlast |=> !out_tvalid || out_tuser == $past(out_tuser), "colour changed within a line")

  // only the defined colour codes are produced
  `BLR_ASSERT_ALWAYS(a_colour_code, !out_tvalid || out_tuser <= COLOUR_FLAT || !rst_n, "bad colour code")

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (.*);

`default_nettype wire
